### rtl/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types and constants for the Horner polynomial evaluation core.
// ----------------------------------------------------------------------------
package hpe_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int PROD_W     = 2 * Q_W;
  localparam int NUM_COEF   = 7;
  localparam int NUM_STEPS  = MAX_DEGREE;
  localparam int DEG_W      = 3;
  localparam int IDX_W      = 3;

  typedef logic        [DEG_W-1:0]  deg_t;
  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [Q_W:0]      sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam idx_t REG_DEGREE = idx_t'(0);
  localparam idx_t REG_COEF_0 = idx_t'(1);

  localparam deg_t DEG_CAP = deg_t'(MAX_DEGREE);

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    q_t   x;
    q_t   acc;
    logic ovf;
  } item_t;

endpackage

### rtl/hpe_step.sv
// ----------------------------------------------------------------------------
// hpe_step
// One Horner step in three register stages: multiply, truncate and clamp
// the product, add the coefficient and clamp the sum.
// ----------------------------------------------------------------------------
module hpe_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  hpe_pkg::item_t up_item,
  output logic          dn_valid,
  input  logic          dn_ready,
  output hpe_pkg::item_t dn_item,
  input  logic          active,
  input  hpe_pkg::q_t   coef
);

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;

  hpe_pkg::item_t a_item, b_item, c_item;
  hpe_pkg::prod_t a_prod;
  hpe_pkg::q_t    b_p;

  hpe_pkg::prod_t prod_full;
  hpe_pkg::prod_t shifted;
  hpe_pkg::prod_t tz;
  logic [hpe_pkg::PROD_W-hpe_pkg::Q_W:0] hi;
  logic           frac_nz;
  logic           sat_b;
  hpe_pkg::q_t    p_clamp;
  hpe_pkg::sum_t  sum;
  logic           sat_c;
  hpe_pkg::q_t    s_clamp;

  assign c_ready  = !c_valid || dn_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  assign prod_full = hpe_pkg::prod_t'(up_item.x) * hpe_pkg::prod_t'(up_item.acc);

  // truncate toward zero
  always_comb begin
    shifted = a_prod >>> hpe_pkg::FRAC_BITS;
    frac_nz = |a_prod[hpe_pkg::FRAC_BITS-1:0];
    tz      = shifted + hpe_pkg::prod_t'(a_prod[hpe_pkg::PROD_W-1] && frac_nz);
    hi      = tz[hpe_pkg::PROD_W-1:hpe_pkg::Q_W-1];
    sat_b   = !((&hi) || !(|hi));
    if (sat_b) begin
      p_clamp = tz[hpe_pkg::PROD_W-1] ? hpe_pkg::Q_MIN : hpe_pkg::Q_MAX;
    end else begin
      p_clamp = tz[hpe_pkg::Q_W-1:0];
    end
  end

  always_comb begin
    sum   = hpe_pkg::sum_t'(coef) + hpe_pkg::sum_t'(b_p);
    sat_c = sum[hpe_pkg::Q_W] != sum[hpe_pkg::Q_W-1];
    if (sat_c) begin
      s_clamp = sum[hpe_pkg::Q_W] ? hpe_pkg::Q_MIN : hpe_pkg::Q_MAX;
    end else begin
      s_clamp = sum[hpe_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= up_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item <= up_item;
      a_prod <= prod_full;
    end
    if (b_ready && a_valid) begin
      b_item.x   <= a_item.x;
      b_item.acc <= a_item.acc;
      b_item.ovf <= a_item.ovf | (active & sat_b);
      b_p        <= p_clamp;
    end
    if (c_ready && b_valid) begin
      c_item.x   <= b_item.x;
      c_item.acc <= active ? s_clamp : b_item.acc;
      c_item.ovf <= b_item.ovf | (active & sat_c);
    end
  end

  assign dn_valid = c_valid;
  assign dn_item  = c_item;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_prod))
    else $error("multiply stage lost or changed a held item");

  ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    b_valid && c_ready && b_item.ovf |=> c_valid && c_item.ovf)
    else $error("overflow flag dropped in add stage");

  idle_pass: assert property (@(posedge clk) disable iff (rst)
    b_valid && c_ready && !active |=> c_item.acc == $past(b_item.acc))
    else $error("inactive step altered the accumulator");

endmodule

### rtl/horner_polynomial_eval_core.sv
// ----------------------------------------------------------------------------
// horner_polynomial_eval_core
// Evaluates a configured polynomial of degree 0 to 6 at each input x by
// Horner's rule in signed Q16.16, saturating every product and sum.
// ----------------------------------------------------------------------------
// One x is taken every cycle when the output is not stalled; it passes through
// one entry stage that picks the top coefficient, then six Horner step units
// of three stages each (multiply, truncate and clamp, add and clamp). Steps
// above the configured degree pass the accumulator through untouched. Write
// the degree and coefficients only while no item is in flight; the overflow
// flag is set if any product or sum of that item saturated.
// ----------------------------------------------------------------------------
module horner_polynomial_eval_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  hpe_pkg::idx_t          cfg_index,
  input  logic [hpe_pkg::Q_W-1:0] cfg_data,
  input  logic                   x_valid,
  output logic                   x_stall,
  input  hpe_pkg::q_t            x_value,
  output logic                   result_valid,
  input  logic                   result_stall,
  output hpe_pkg::q_t            poly_value,
  output logic                   overflow
);

  hpe_pkg::deg_t degree;
  hpe_pkg::q_t   coef [hpe_pkg::NUM_COEF];
  hpe_pkg::deg_t deg_eff;

  logic           e_valid;
  logic           e_ready;
  hpe_pkg::item_t e_item;

  logic           v   [hpe_pkg::NUM_STEPS+1];
  logic           rdy [hpe_pkg::NUM_STEPS+1];
  hpe_pkg::item_t it  [hpe_pkg::NUM_STEPS+1];
  logic           act [hpe_pkg::NUM_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int i = 0; i < hpe_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        hpe_pkg::REG_DEGREE: degree <= cfg_data[hpe_pkg::DEG_W-1:0];
        default:             coef[cfg_index - hpe_pkg::REG_COEF_0] <= cfg_data;
      endcase
    end
  end

  assign deg_eff = (degree > hpe_pkg::DEG_CAP) ? hpe_pkg::DEG_CAP : degree;

  assign e_ready = !e_valid || rdy[0];
  assign x_stall = !e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && x_valid) begin
      e_item.x   <= x_value;
      e_item.acc <= coef[deg_eff];
      e_item.ovf <= 1'b0;
    end
  end

  assign v[0]  = e_valid;
  assign it[0] = e_item;

  for (genvar j = 0; j < hpe_pkg::NUM_STEPS; j++) begin : g_step
    localparam int K = hpe_pkg::MAX_DEGREE - j;

    assign act[j] = hpe_pkg::deg_t'(K) <= deg_eff;

    hpe_step u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v[j]),
      .up_ready (rdy[j]),
      .up_item  (it[j]),
      .dn_valid (v[j+1]),
      .dn_ready (rdy[j+1]),
      .dn_item  (it[j+1]),
      .active   (act[j]),
      .coef     (coef[K-1])
    );
  end

  assign rdy[hpe_pkg::NUM_STEPS] = !result_stall;
  assign result_valid = v[hpe_pkg::NUM_STEPS];
  assign poly_value   = it[hpe_pkg::NUM_STEPS].acc;
  assign overflow     = it[hpe_pkg::NUM_STEPS].ovf;

endmodule
